// ===== design/kmh_pkg.sv =====
// ----------------------------------------------------------------------------
// kmh_pkg
// Shared types and constants for the k-mer histogram counter: request and
// result payloads, request codes and default sizing.
// ----------------------------------------------------------------------------
package kmh_pkg;

	// default sizing
	localparam int MAX_K_DEF      = 8;
	localparam int COUNT_BITS_DEF = 32;

	// k register
	localparam int        KLEN_W     = 4;
	localparam logic [3:0] KLEN_RESET = 4'd4;

	// request codes
	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// request payload
	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  base;
		logic [15:0] kmer_index;
	} kmh_req_t;

	// result payload
	typedef struct packed {
		logic [31:0] count;
		logic        window_full;
		logic        saturated;
	} kmh_res_t;

endpackage

// ===== design/kmer_histogram_counter.sv =====
// ----------------------------------------------------------------------------
// kmer_histogram_counter
// Counts every k-mer of a 2-bit DNA base stream in a table of 4^MAX_K
// saturating counters held in one synchronous memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with result_valid, and the receiver cannot
// stall it. A push that completes a window and a query read the counter
// through the memory read port when taken; in the UPDATE state a push writes
// the incremented value back and both register the result. A push that does
// not yet fill the window and the unused code register their result when
// taken. A clear, and reset itself, start a clearing pass that writes zero to
// one entry per cycle over all 4^MAX_K entries (65536 at MAX_K = 8), with busy
// high; a clear's result appears in the pass's first cycle. The k register
// (cfg_data) is always ready and is meant to be written while idle.
// ----------------------------------------------------------------------------
module kmer_histogram_counter #(
	parameter int MAX_K      = kmh_pkg::MAX_K_DEF,
	parameter int COUNT_BITS = kmh_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  kmh_pkg::kmh_req_t             req,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kmh_pkg::KLEN_W-1:0]    cfg_data,
	output logic                          result_valid,
	output kmh_pkg::kmh_res_t             result
);
	import kmh_pkg::*;

	localparam int AW    = 2 * MAX_K;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = $clog2(MAX_K + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_UPDATE = 2'd1;
	localparam logic [1:0] ST_CLEAR  = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [SW-1:0]         SEEN_MAX  = SW'(MAX_K);
	localparam logic [KLEN_W-1:0]     K_MAX     = KLEN_W'(MAX_K);

	logic [1:0]            state_q;
	logic [KLEN_W-1:0]     klen_q;
	logic [AW-1:0]         hist_q;
	logic [SW-1:0]         seen_q;
	logic [AW-1:0]         clr_addr_q;
	logic                  push_s1;
	logic [AW-1:0]         addr_s1;
	logic [COUNT_BITS-1:0] rd_q;
	logic                  result_valid_q;
	kmh_res_t              result_q;

	logic                  accept;
	logic [KLEN_W-1:0]     k_eff;
	logic [AW-1:0]         kmask;
	logic [AW-1:0]         hist_nxt;
	logic [SW-1:0]         seen_nxt;
	logic                  win_full;
	logic [AW-1:0]         rd_addr;
	logic                  rd_en;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	logic [COUNT_BITS-1:0] mem [DEPTH];

	// handshake
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// effective k and its index mask
	always_comb begin
		if (klen_q == '0)
			k_eff = KLEN_W'(1);
		else if (klen_q > K_MAX)
			k_eff = K_MAX;
		else
			k_eff = klen_q;
	end
	assign kmask = ~({AW{1'b1}} << {k_eff, 1'b0});

	// window update for a push
	assign hist_nxt = (hist_q << 2) | AW'(req.base);
	assign seen_nxt = (seen_q < SEEN_MAX) ? seen_q + SW'(1) : seen_q;
	assign win_full = (KLEN_W'(seen_nxt) >= k_eff);

	// read address and enable
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(req.kmer_index) & kmask;
		if (accept) begin
			case (req.req_type)
				REQ_PUSH: begin
					rd_en   = win_full;
					rd_addr = hist_nxt & kmask;
				end
				REQ_QUERY: begin
					rd_en = 1'b1;
				end
				default: begin
					rd_en = 1'b0;
				end
			endcase
		end
	end

	// saturating increment of the read counter
	assign cnt_inc = (rd_q == COUNT_MAX) ? rd_q : rd_q + COUNT_BITS'(1);

	// write port: write-back of a push or the clearing pass
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = cnt_inc;
		if (state_q == ST_UPDATE && push_s1) begin
			mem_we = 1'b1;
		end else if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end
	end

	// counter memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// request pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			push_s1 <= (req.req_type == REQ_PUSH);
			addr_s1 <= rd_addr;
		end
	end

	// control, window state and k register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			klen_q         <= KLEN_RESET;
			hist_q         <= '0;
			seen_q         <= '0;
			clr_addr_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				klen_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_PUSH: begin
								hist_q <= hist_nxt;
								seen_q <= seen_nxt;
								if (win_full)
									state_q <= ST_UPDATE;
								else
									result_valid_q <= 1'b1;
							end
							REQ_QUERY: begin
								state_q <= ST_UPDATE;
							end
							REQ_CLEAR: begin
								hist_q         <= '0;
								seen_q         <= '0;
								clr_addr_q     <= '0;
								state_q        <= ST_CLEAR;
								result_valid_q <= 1'b1;
							end
							default: begin
								result_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_UPDATE: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == {AW{1'b1}})
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register: zeros unless a counter was read
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			if (push_s1) begin
				result_q.count       <= 32'(cnt_inc);
				result_q.window_full <= 1'b1;
				result_q.saturated   <= (cnt_inc == COUNT_MAX);
			end else begin
				result_q.count       <= 32'(rd_q);
				result_q.window_full <= 1'b0;
				result_q.saturated   <= (rd_q == COUNT_MAX);
			end
		end else if (accept) begin
			result_q <= '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for kmer_histogram_counter. Requests go in over the
// start/busy handshake, the k register over its own write channel. A
// behavioral copy of the counter table, base window and k predicts each
// result at the moment its request is taken; results are checked in order,
// field by field. Directed cases come first, then random base streams under
// several k settings and sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
	import kmh_pkg::*;

	// request code left unused by the block
	localparam logic [1:0]  REQ_UNUSED    = 2'd3;
	localparam logic [31:0] COUNT_CEILING = '1;
	localparam int          MAX_REPORTS   = 10;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	kmh_req_t req;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [KLEN_W-1:0] cfg_data;
	logic     result_valid;
	kmh_res_t result;

	// predicted block state
	logic [31:0]       kmer_counts [logic [15:0]];
	logic [15:0]       window_bases;
	int                bases_in_window;
	logic [KLEN_W-1:0] kmer_length;

	kmh_res_t awaited_results [$];
	int       mismatch_count = 0;
	int       sender_idle_pct = 0;

	kmer_histogram_counter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	// clock
	always #2 clk = ~clk;

	// hard stop on a hung run
	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// k as the block applies it: 0 acts as 1, above MAX_K acts as MAX_K
	function automatic int active_k();
		if (kmer_length == 0)
			return 1;
		if (kmer_length > MAX_K_DEF)
			return MAX_K_DEF;
		return int'(kmer_length);
	endfunction

	function automatic logic [15:0] window_mask(input int k);
		logic [31:0] wide;
		wide = (32'd1 << (2 * k)) - 32'd1;
		return wide[15:0];
	endfunction

	function automatic logic [31:0] stored_count(input logic [15:0] idx);
		if (kmer_counts.exists(idx))
			return kmer_counts[idx];
		return 32'd0;
	endfunction

	function automatic void reset_counter_model();
		kmer_counts.delete();
		window_bases    = '0;
		bases_in_window = 0;
		kmer_length     = KLEN_RESET;
	endfunction

	// apply one request to the predicted state and return its result
	function automatic kmh_res_t tally_request(input kmh_req_t r);
		kmh_res_t    res;
		logic [15:0] idx;
		logic [31:0] cnt;
		int          k;
		res = '0;
		k   = active_k();
		case (r.req_type)
			REQ_PUSH: begin
				window_bases = {window_bases[13:0], r.base};
				if (bases_in_window < MAX_K_DEF)
					bases_in_window++;
				if (bases_in_window >= k) begin
					idx = window_bases & window_mask(k);
					cnt = stored_count(idx);
					if (cnt != COUNT_CEILING)
						cnt++;
					kmer_counts[idx] = cnt;
					res.count       = cnt;
					res.window_full = 1'b1;
					res.saturated   = (cnt == COUNT_CEILING);
				end
			end
			REQ_QUERY: begin
				idx = r.kmer_index & window_mask(k);
				cnt = stored_count(idx);
				res.count     = cnt;
				res.saturated = (cnt == COUNT_CEILING);
			end
			REQ_CLEAR: begin
				kmer_counts.delete();
				window_bases    = '0;
				bases_in_window = 0;
			end
			default: ;
		endcase
		return res;
	endfunction

	// one request transfer; the prediction is taken at the accepting edge
	task automatic issue_request(input logic [1:0] code, input logic [1:0] nt,
			input logic [15:0] idx);
		kmh_req_t r;
		r.req_type   = code;
		r.base       = nt;
		r.kmer_index = idx;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		awaited_results.push_back(tally_request(r));
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	// write k once all results are in and the block is idle
	task automatic write_kmer_length(input logic [KLEN_W-1:0] k);
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		kmer_length = k;
	endtask

	// result checker
	always @(posedge clk) begin
		kmh_res_t want;
		if (arst_n && result_valid) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: count=%0d window_full=%0b saturated=%0b",
						result.count, result.window_full, result.saturated);
			end else begin
				want = awaited_results.pop_front();
				if (result.count !== want.count || result.window_full !== want.window_full ||
						result.saturated !== want.saturated) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch at %0t: count %0d/%0d window_full %0b/%0b saturated %0b/%0b (exp/act)",
							$realtime, want.count, result.count, want.window_full,
							result.window_full, want.saturated, result.saturated);
				end
			end
		end
	end

	// empty table after the reset clearing pass, default k
	task automatic test_reset_state();
		issue_request(REQ_QUERY, 2'd0, 16'h0000);
		issue_request(REQ_QUERY, 2'd3, 16'hFFFF);
	endtask

	// pushes before the window fills, first counted k-mer, query high bits ignored
	task automatic test_window_fill();
		issue_request(REQ_PUSH, 2'd0, 16'hFFFF);
		issue_request(REQ_PUSH, 2'd1, 16'h0000);
		issue_request(REQ_PUSH, 2'd2, 16'hAAAA);
		issue_request(REQ_PUSH, 2'd3, 16'h5555);
		issue_request(REQ_PUSH, 2'd3, 16'h0000);
		issue_request(REQ_QUERY, 2'd0, 16'hFF1B);
	endtask

	// same k-mer back to back checks the read-modify-write of consecutive pushes
	task automatic test_repeated_kmer();
		write_kmer_length(4'd1);
		issue_request(REQ_PUSH, 2'd3, 16'h0000);
		issue_request(REQ_PUSH, 2'd3, 16'hFFFF);
		issue_request(REQ_PUSH, 2'd3, 16'h1234);
		issue_request(REQ_QUERY, 2'd0, 16'hFFF3);
	endtask

	// k of zero and above MAX_K, window history kept across the change
	task automatic test_kmer_length_limits();
		write_kmer_length(4'd0);
		issue_request(REQ_PUSH, 2'd0, 16'hFFFF);
		issue_request(REQ_QUERY, 2'd1, 16'hFFFC);
		write_kmer_length(4'd15);
		issue_request(REQ_PUSH, 2'd1, 16'h0000);
		issue_request(REQ_QUERY, 2'd2, 16'hFFFF);
	endtask

	// unused code changes nothing and returns zeros
	task automatic test_unused_code();
		issue_request(REQ_UNUSED, 2'd3, 16'hFFFF);
		issue_request(REQ_QUERY, 2'd0, 16'h0000);
	endtask

	// clear empties the table and the window
	task automatic test_clear();
		issue_request(REQ_CLEAR, 2'd3, 16'hFFFF);
		issue_request(REQ_PUSH, 2'd3, 16'h0000);
		issue_request(REQ_QUERY, 2'd0, 16'h0000);
	endtask

	// biased base streams with queries that mostly hit the current window
	task automatic test_random_traffic(input int n_items, input int idle_pct,
			input logic [KLEN_W-1:0] k);
		int          clear_slot;
		int          pick;
		logic [15:0] idx;
		logic [15:0] mask;
		logic [1:0]  nt;
		write_kmer_length(k);
		sender_idle_pct = idle_pct;
		clear_slot = $urandom_range(n_items - 1);
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			idx  = 16'($urandom_range(16'hFFFF));
			nt   = 2'($urandom_range(3));
			if (i == clear_slot) begin
				issue_request(REQ_CLEAR, nt, idx);
			end else if (pick < 62) begin
				// half of the bases from a two-letter alphabet so k-mers repeat
				if ($urandom_range(1) == 1)
					nt = 2'($urandom_range(1));
				issue_request(REQ_PUSH, nt, idx);
			end else if (pick < 96) begin
				mask = window_mask(active_k());
				if ($urandom_range(9) < 7)
					idx = (idx & ~mask) | (window_bases & mask);
				issue_request(REQ_QUERY, nt, idx);
			end else begin
				issue_request(REQ_UNUSED, nt, idx);
			end
		end
		sender_idle_pct = 0;
	endtask

	// test sequence
	initial begin
		logic [KLEN_W-1:0] mid_k;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		reset_counter_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_window_fill();
		test_repeated_kmer();
		test_kmer_length_limits();
		test_unused_code();
		test_clear();

		mid_k = KLEN_W'($urandom_range(7, 2));
		test_random_traffic(320, 0, 4'd8);
		test_random_traffic(320, 75, 4'd1);
		test_random_traffic(320, 0, mid_k);
		test_random_traffic(320, 34, 4'd15);

		// drain and watch for stray results
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
